// ===== hdl/cyk_pkg.sv =====
// Shared types and constants for the CYK recognizer.
// No dependencies; cyk_if, cyk_rule_store and the top level refer to this package.
`default_nettype none
package cyk_pkg;

  localparam int SYM_W      = 8;
  localparam int NT_IDX_W   = 4;
  localparam int MASK_OUT_W = 16;

  localparam logic [1:0] OP_TERM  = 2'd0;
  localparam logic [1:0] OP_BIN   = 2'd1;
  localparam logic [1:0] OP_PUSH  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  typedef struct packed {
    logic                term_we;
    logic                bin_we;
    logic                clear;
    logic [SYM_W-1:0]    symbol;
    logic [NT_IDX_W-1:0] head;
    logic [NT_IDX_W-1:0] left_child;
    logic [NT_IDX_W-1:0] right_child;
  } rule_load_t;

  typedef struct packed {
    logic [NT_IDX_W-1:0] head;
    logic [SYM_W-1:0]    symbol;
  } term_rule_t;

  typedef struct packed {
    logic [NT_IDX_W-1:0] head;
    logic [NT_IDX_W-1:0] left_child;
    logic [NT_IDX_W-1:0] right_child;
  } bin_rule_t;

endpackage
`default_nettype wire

// ===== hdl/cyk_if.sv =====
// Valid/ready channel interfaces for input items and result items.
// Depends on cyk_pkg for field widths.
`default_nettype none
interface cyk_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    op;
  logic [cyk_pkg::SYM_W-1:0]     symbol;
  logic [cyk_pkg::NT_IDX_W-1:0]  head;
  logic [cyk_pkg::NT_IDX_W-1:0]  left_child;
  logic [cyk_pkg::NT_IDX_W-1:0]  right_child;
  logic                          last;
  modport source (output valid, op, symbol, head, left_child, right_child, last,
                  input ready);
  modport sink (input valid, op, symbol, head, left_child, right_child, last,
                output ready);
endinterface

interface cyk_out_if;
  logic                            valid;
  logic                            ready;
  logic                            accepted;
  logic [cyk_pkg::MASK_OUT_W-1:0]  root_mask;
  logic                            too_long;
  logic                            rules_dropped;
  modport source (output valid, accepted, root_mask, too_long, rules_dropped,
                  input ready);
  modport sink (input valid, accepted, root_mask, too_long, rules_dropped,
                output ready);
endinterface
`default_nettype wire

// ===== hdl/cyk_rule_store.sv =====
// Terminal and binary rule memories with their fill counts and drop flag.
// Depends on cyk_pkg.
`default_nettype none
module cyk_rule_store #(
  parameter int NONTERMINALS = 16,
  parameter int TERM_RULES   = 32,
  parameter int BIN_RULES    = 64
) (
  input  wire logic                                              clk,
  input  wire logic                                              rst_n,
  input  wire cyk_pkg::rule_load_t                               load,
  input  wire logic [((TERM_RULES > 1) ? $clog2(TERM_RULES) : 1)-1:0] term_raddr,
  input  wire logic [((BIN_RULES > 1) ? $clog2(BIN_RULES) : 1)-1:0]   bin_raddr,
  output cyk_pkg::term_rule_t                                    term_rdata,
  output cyk_pkg::bin_rule_t                                     bin_rdata,
  output logic [$clog2(TERM_RULES+1)-1:0]                        term_cnt,
  output logic [$clog2(BIN_RULES+1)-1:0]                         bin_cnt,
  output logic                                                   dropped
);
  localparam int TAW = (TERM_RULES > 1) ? $clog2(TERM_RULES) : 1;
  localparam int BAW = (BIN_RULES > 1) ? $clog2(BIN_RULES) : 1;
  localparam int TCW = $clog2(TERM_RULES+1);
  localparam int BCW = $clog2(BIN_RULES+1);

  cyk_pkg::term_rule_t term_mem [TERM_RULES];
  cyk_pkg::bin_rule_t  bin_mem  [BIN_RULES];

  logic [TCW-1:0] term_cnt_r;
  logic [BCW-1:0] bin_cnt_r;
  logic           dropped_r;
  logic           term_ok;
  logic           bin_ok;

  always_comb begin
    term_ok = (int'(load.head) < NONTERMINALS) && (int'(term_cnt_r) < TERM_RULES);
    bin_ok  = (int'(load.head) < NONTERMINALS) &&
              (int'(load.left_child) < NONTERMINALS) &&
              (int'(load.right_child) < NONTERMINALS) &&
              (int'(bin_cnt_r) < BIN_RULES);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_cnt_r <= '0;
      bin_cnt_r  <= '0;
      dropped_r  <= 1'b0;
    end else if (load.clear) begin
      term_cnt_r <= '0;
      bin_cnt_r  <= '0;
      dropped_r  <= 1'b0;
    end else if (load.term_we) begin
      if (term_ok) term_cnt_r <= term_cnt_r + 1'b1;
      else dropped_r <= 1'b1;
    end else if (load.bin_we) begin
      if (bin_ok) bin_cnt_r <= bin_cnt_r + 1'b1;
      else dropped_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load.term_we && term_ok) begin
      term_mem[term_cnt_r[TAW-1:0]] <= '{head: load.head, symbol: load.symbol};
    end
    if (load.bin_we && bin_ok) begin
      bin_mem[bin_cnt_r[BAW-1:0]] <= '{head: load.head, left_child: load.left_child,
                                      right_child: load.right_child};
    end
    term_rdata <= term_mem[term_raddr];
    bin_rdata  <= bin_mem[bin_raddr];
  end

  assign term_cnt = term_cnt_r;
  assign bin_cnt  = bin_cnt_r;
  assign dropped  = dropped_r;
endmodule
`default_nettype wire

// ===== hdl/cyk_span_mem.sv =====
// Span table memory: one write port, two registered read ports.
// Entry address is the row index followed by the column index.
`default_nettype none
module cyk_span_mem #(
  parameter int MAX_LEN      = 32,
  parameter int NONTERMINALS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [2*$clog2(MAX_LEN)-1:0]     waddr,
  input  wire logic [NONTERMINALS-1:0]          wdata,
  input  wire logic [2*$clog2(MAX_LEN)-1:0]     raddr_a,
  input  wire logic [2*$clog2(MAX_LEN)-1:0]     raddr_b,
  output logic      [NONTERMINALS-1:0]          rdata_a,
  output logic      [NONTERMINALS-1:0]          rdata_b
);
  localparam int IW    = $clog2(MAX_LEN);
  localparam int DEPTH = 1 << (2*IW);

  logic [NONTERMINALS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule
`default_nettype wire

// ===== hdl/cyk_membership_check_top.sv =====
// CYK recognizer top level; uses cyk_pkg, cyk_if, cyk_rule_store, cyk_span_mem.
// Rule loads, clears and non-final characters past the limit are handled in the idle state. A
// stored character is matched against every terminal rule loaded. A final character then
// fills every span, scanning every binary rule loaded at each split point of the span, and
// the root cell is read for the result.
// One item at a time; synchronous active-low reset empties rules, string and flags.
`default_nettype none
module cyk_membership_check_top #(
  parameter int MAX_LEN      = 32,
  parameter int NONTERMINALS = 16,
  parameter int TERM_RULES   = 32,
  parameter int BIN_RULES    = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  cyk_in_if.sink                             in_ch,
  cyk_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [cyk_pkg::NT_IDX_W-1:0]  cfg_wdata
);
  localparam int IW    = $clog2(MAX_LEN);
  localparam int LW    = $clog2(MAX_LEN+1);
  localparam int TCW   = $clog2(TERM_RULES+1);
  localparam int BCW   = $clog2(BIN_RULES+1);
  localparam int TAW   = (TERM_RULES > 1) ? $clog2(TERM_RULES) : 1;
  localparam int BAW   = (BIN_RULES > 1) ? $clog2(BIN_RULES) : 1;
  localparam int OUT_W = cyk_pkg::MASK_OUT_W;
  localparam int NT    = NONTERMINALS;

  // Sequencer states.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_TSCAN  = 4'd1;
  localparam logic [3:0] S_FSTART = 4'd2;
  localparam logic [3:0] S_FSPLIT = 4'd3;
  localparam logic [3:0] S_FLATCH = 4'd4;
  localparam logic [3:0] S_FRULE  = 4'd5;
  localparam logic [3:0] S_ROOT   = 4'd6;
  localparam logic [3:0] S_RLAT   = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0]                      state_r;
  logic [LW-1:0]                   len_r;
  logic                            ovf_r;
  logic [cyk_pkg::NT_IDX_W-1:0]    start_r;
  logic [cyk_pkg::SYM_W-1:0]       sym_r;
  logic                            last_r;
  logic [TCW-1:0]                  tr_r;
  logic                            tv_r;
  logic [BCW-1:0]                  br_r;
  logic                            bv_r;
  logic [NT-1:0]                   acc_r;
  logic [NT-1:0]                   a_r;
  logic [NT-1:0]                   b_r;
  logic [NT-1:0]                   root_r;
  logic [LW-1:0]                   i_r;
  logic [LW-1:0]                   j_r;
  logic [LW-1:0]                   k_r;
  logic [LW-1:0]                   l_r;

  logic                            out_valid_r;
  logic                            out_acc_r;
  logic [OUT_W-1:0]                out_mask_r;
  logic                            out_long_r;
  logic                            out_drop_r;

  cyk_pkg::rule_load_t             load;
  cyk_pkg::term_rule_t             term_rd;
  cyk_pkg::bin_rule_t              bin_rd;
  logic [TCW-1:0]                  term_cnt;
  logic [BCW-1:0]                  bin_cnt;
  logic                            dropped;

  logic                            span_we;
  logic [2*IW-1:0]                 span_waddr;
  logic [NT-1:0]                   span_wdata;
  logic [NT-1:0]                   span_rd_a;
  logic [NT-1:0]                   span_rd_b;
  logic [LW-1:0]                   k_next;

  logic                            in_fire;
  logic                            t_more, t_hit, t_done;
  logic                            b_more, b_hit, b_done;
  logic                            split_more;
  logic                            out_free;
  logic [OUT_W+NT-1:0]             root_wide;
  logic                            start_hit;

  // The block takes an item only between strings' work; a result already
  // waiting in the output register does not hold back the input side.
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  always_comb begin
    load.term_we     = in_fire && (in_ch.op == cyk_pkg::OP_TERM);
    load.bin_we      = in_fire && (in_ch.op == cyk_pkg::OP_BIN);
    load.clear       = in_fire && (in_ch.op == cyk_pkg::OP_CLEAR);
    load.symbol      = in_ch.symbol;
    load.head        = in_ch.head;
    load.left_child  = in_ch.left_child;
    load.right_child = in_ch.right_child;
  end

  cyk_rule_store #(
    .NONTERMINALS (NONTERMINALS),
    .TERM_RULES   (TERM_RULES),
    .BIN_RULES    (BIN_RULES)
  ) u_rules (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .term_raddr (tr_r[TAW-1:0]),
    .bin_raddr  (br_r[BAW-1:0]),
    .term_rdata (term_rd),
    .bin_rdata  (bin_rd),
    .term_cnt   (term_cnt),
    .bin_cnt    (bin_cnt),
    .dropped    (dropped)
  );

  // The left operand of a split is cell [i][k], the right one [k+1][j]. The
  // root read reuses the left port with i = 0 and k = n-1.
  assign k_next = k_r + 1'b1;

  cyk_span_mem #(
    .MAX_LEN      (MAX_LEN),
    .NONTERMINALS (NONTERMINALS)
  ) u_span (
    .clk     (clk),
    .we      (span_we),
    .waddr   (span_waddr),
    .wdata   (span_wdata),
    .raddr_a ({i_r[IW-1:0], k_r[IW-1:0]}),
    .raddr_b ({k_next[IW-1:0], j_r[IW-1:0]}),
    .rdata_a (span_rd_a),
    .rdata_b (span_rd_b)
  );

  // Rule scans issue one read per cycle; the valid flag is registered alongside the read
  // data, and a scan ends once no read is left in flight.
  always_comb begin
    t_more     = tr_r < term_cnt;
    t_hit      = tv_r && (term_rd.symbol == sym_r);
    t_done     = !t_more && !tv_r;
    b_more     = br_r < bin_cnt;
    b_hit      = bv_r && ((a_r >> bin_rd.left_child) & NT'(1)) != '0
                 && ((b_r >> bin_rd.right_child) & NT'(1)) != '0;
    b_done     = !b_more && !bv_r;
    split_more = k_next < j_r;

    span_we    = 1'b0;
    span_waddr = {i_r[IW-1:0], j_r[IW-1:0]};
    span_wdata = acc_r;
    if (state_r == S_TSCAN && t_done) begin
      span_we    = 1'b1;
      span_waddr = {len_r[IW-1:0], len_r[IW-1:0]};
    end else if (state_r == S_FRULE && b_done && !split_more) begin
      span_we = 1'b1;
    end
  end

  assign root_wide = {{OUT_W{1'b0}}, root_r};
  assign start_hit = (int'(start_r) < NONTERMINALS) && (((root_r >> start_r) & NT'(1)) != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
    end else if (cfg_we) begin
      start_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      ovf_r       <= 1'b0;
      sym_r       <= '0;
      last_r      <= 1'b0;
      tr_r        <= '0;
      tv_r        <= 1'b0;
      br_r        <= '0;
      bv_r        <= 1'b0;
      acc_r       <= '0;
      a_r         <= '0;
      b_r         <= '0;
      root_r      <= '0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      l_r         <= '0;
      out_valid_r <= 1'b0;
      out_acc_r   <= 1'b0;
      out_mask_r  <= '0;
      out_long_r  <= 1'b0;
      out_drop_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_fire && in_ch.op == cyk_pkg::OP_PUSH) begin
            sym_r  <= in_ch.symbol;
            last_r <= in_ch.last;
            if (int'(len_r) < MAX_LEN) begin
              tr_r    <= '0;
              tv_r    <= 1'b0;
              acc_r   <= '0;
              state_r <= S_TSCAN;
            end else begin
              // A character past the limit is dropped and marks the string.
              ovf_r <= 1'b1;
              if (in_ch.last) begin
                root_r  <= '0;
                state_r <= S_DONE;
              end
            end
          end
        end
        S_TSCAN: begin
          if (t_more) tr_r <= tr_r + 1'b1;
          tv_r <= t_more;
          if (t_hit) acc_r <= acc_r | (NT'(1) << term_rd.head);
          if (t_done) begin
            len_r <= len_r + 1'b1;
            if (!last_r) state_r <= S_IDLE;
            else if (ovf_r) begin
              root_r  <= '0;
              state_r <= S_DONE;
            end else state_r <= S_FSTART;
          end
        end
        S_FSTART: begin
          i_r   <= '0;
          acc_r <= '0;
          if (int'(len_r) >= 2) begin
            l_r     <= LW'(2);
            j_r     <= LW'(1);
            k_r     <= '0;
            state_r <= S_FSPLIT;
          end else begin
            k_r     <= len_r - 1'b1;
            state_r <= S_ROOT;
          end
        end
        S_FSPLIT: begin
          state_r <= S_FLATCH;
        end
        S_FLATCH: begin
          a_r     <= span_rd_a;
          b_r     <= span_rd_b;
          br_r    <= '0;
          bv_r    <= 1'b0;
          state_r <= S_FRULE;
        end
        S_FRULE: begin
          if (b_more) br_r <= br_r + 1'b1;
          bv_r <= b_more;
          if (b_hit) acc_r <= acc_r | (NT'(1) << bin_rd.head);
          if (b_done) begin
            if (split_more) begin
              k_r     <= k_next;
              state_r <= S_FSPLIT;
            end else begin
              // Cell finished and written this cycle; step to the next cell.
              acc_r <= '0;
              if (({1'b0, i_r} + {1'b0, l_r}) < {1'b0, len_r}) begin
                i_r     <= i_r + 1'b1;
                j_r     <= j_r + 1'b1;
                k_r     <= i_r + 1'b1;
                state_r <= S_FSPLIT;
              end else if (l_r < len_r) begin
                l_r     <= l_r + 1'b1;
                i_r     <= '0;
                j_r     <= l_r;
                k_r     <= '0;
                state_r <= S_FSPLIT;
              end else begin
                i_r     <= '0;
                k_r     <= len_r - 1'b1;
                state_r <= S_ROOT;
              end
            end
          end
        end
        S_ROOT: begin
          state_r <= S_RLAT;
        end
        S_RLAT: begin
          root_r  <= span_rd_a;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_acc_r   <= start_hit;
            out_mask_r  <= root_wide[OUT_W-1:0];
            out_long_r  <= ovf_r;
            out_drop_r  <= dropped;
            len_r       <= '0;
            ovf_r       <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.accepted      = out_acc_r;
  assign out_ch.root_mask     = out_mask_r;
  assign out_ch.too_long      = out_long_r;
  assign out_ch.rules_dropped = out_drop_r;

  // The stored string never grows past the span table.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(len_r) <= MAX_LEN)
    else $error("string length beyond table size");

  // A split is only evaluated strictly inside its span.
  a_split_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FRULE) |-> (k_r < j_r && i_r <= k_r))
    else $error("split point outside span");

  // A new result is only produced from the result state.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside result state");

  // Handing over a result empties the string state.
  a_string_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=> (len_r == '0 && !ovf_r && state_r == S_IDLE))
    else $error("string state not emptied after result");

endmodule
`default_nettype wire
